### rtl/itoa_pkg.sv
// Package for the integer to ASCII formatter: field widths, character codes,
// microcode word layout, the microcode ROM and the BCD shift step.
// No dependencies.
package itoa_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int OPERAND_W           = 64;
   localparam int FUNC_W              = 2;
   localparam int CHAR_W              = 7;
   localparam int BCD_DIGITS          = 20;
   localparam int BCD_W               = 4 * BCD_DIGITS;
   localparam int PC_W                = 4;
   localparam int CNT_W               = 5;

   // format selector codes
   localparam logic [FUNC_W-1:0] FMT_SIGNED   = 2'd0;
   localparam logic [FUNC_W-1:0] FMT_UNSIGNED = 2'd1;
   localparam logic [FUNC_W-1:0] FMT_HEX      = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;

   // nibble counts for the two operand widths, and the BCD digit count
   localparam logic [CNT_W-1:0] NIBBLES_WIDE   = 5'd16;
   localparam logic [CNT_W-1:0] NIBBLES_NARROW = 5'd8;
   localparam logic [CNT_W-1:0] DIGITS_ALL     = 5'd20;

   typedef enum logic [3:0] {
      OP_NOP        = 4'd0,
      OP_LOAD       = 4'd1,
      OP_EMIT_CONST = 4'd2,
      OP_DABBLE     = 4'd3,
      OP_SET_DIGITS = 4'd4,
      OP_SKIP       = 4'd5,
      OP_EMIT_DEC   = 4'd6,
      OP_EMIT_HEX   = 4'd7
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_IDLE     = 3'd2,
      COND_FUNC_BAD = 3'd3,
      COND_FUNC_HEX = 3'd4,
      COND_POSITIVE = 3'd5,
      COND_CNT_MORE = 3'd6,
      COND_SKIP     = 3'd7
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
      logic [CHAR_W-1:0] chr;
   } ctrl_word_type;

   // step addresses used as jump targets
   localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
   localparam logic [PC_W-1:0] PC_DABBLE = 4'd5;
   localparam logic [PC_W-1:0] PC_SKIP   = 4'd7;
   localparam logic [PC_W-1:0] PC_DEC    = 4'd8;
   localparam logic [PC_W-1:0] PC_HEX0   = 4'd10;
   localparam logic [PC_W-1:0] PC_HEX    = 4'd12;
   localparam logic [PC_W-1:0] PC_NONE   = 4'd0;

   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_IDLE, chr: CHAR_ZERO};
      case (pc)
         4'd0:  w = '{op: OP_LOAD,       cond: COND_IDLE,     target: PC_IDLE,
                     chr: CHAR_ZERO};
         4'd1:  w = '{op: OP_NOP,        cond: COND_FUNC_BAD, target: PC_IDLE,
                     chr: CHAR_ZERO};
         4'd2:  w = '{op: OP_NOP,        cond: COND_FUNC_HEX, target: PC_HEX0,
                     chr: CHAR_ZERO};
         4'd3:  w = '{op: OP_NOP,        cond: COND_POSITIVE, target: PC_DABBLE,
                     chr: CHAR_ZERO};
         4'd4:  w = '{op: OP_EMIT_CONST, cond: COND_NEXT,     target: PC_NONE,
                     chr: CHAR_MINUS};
         4'd5:  w = '{op: OP_DABBLE,     cond: COND_CNT_MORE, target: PC_DABBLE,
                     chr: CHAR_ZERO};
         4'd6:  w = '{op: OP_SET_DIGITS, cond: COND_NEXT,     target: PC_NONE,
                     chr: CHAR_ZERO};
         4'd7:  w = '{op: OP_SKIP,       cond: COND_SKIP,     target: PC_SKIP,
                     chr: CHAR_ZERO};
         4'd8:  w = '{op: OP_EMIT_DEC,   cond: COND_CNT_MORE, target: PC_DEC,
                     chr: CHAR_ZERO};
         4'd9:  w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: PC_IDLE,
                     chr: CHAR_ZERO};
         4'd10: w = '{op: OP_EMIT_CONST, cond: COND_NEXT,     target: PC_NONE,
                     chr: CHAR_ZERO};
         4'd11: w = '{op: OP_EMIT_CONST, cond: COND_NEXT,     target: PC_NONE,
                     chr: CHAR_X};
         4'd12: w = '{op: OP_EMIT_HEX,   cond: COND_CNT_MORE, target: PC_HEX,
                     chr: CHAR_ZERO};
         4'd13: w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: PC_IDLE,
                     chr: CHAR_ZERO};
         default: w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: PC_IDLE,
                     chr: CHAR_ZERO};
      endcase
      return w;
   endfunction

   // one double-dabble step: correct every digit, then shift in one bit
   function automatic logic [BCD_W-1:0] bcd_shift(input logic [BCD_W-1:0] bcd,
                                                  input logic din);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], din};
   endfunction

endpackage

### rtl/itoa_if.sv
// Handshake channels of the integer to ASCII formatter: request and response.
// Depends on itoa_pkg for the field widths.
interface itoa_req_if;
   logic                              valid;
   logic                              ready;
   logic [itoa_pkg::FUNC_W-1:0]       func;
   logic                              wide;
   logic [itoa_pkg::OPERAND_W-1:0]    value;

   modport source (output valid, output func, output wide, output value, input ready);
   modport sink   (input valid, input func, input wide, input value, output ready);
endinterface

interface itoa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [itoa_pkg::CHAR_W-1:0]       character;
   logic                              last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

### rtl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter. A 14-step microcode ROM sequences a 64-bit
// shift register, a 20-digit BCD register (4 dabble steps per cycle) and a
// one-word output register; a word is taken only in the wait step, which a
// closing step reaches after the last character is registered. Output stalls
// hold the sequence in its emit step. Reset: to wait step.
module integer_to_ascii_formatter #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   itoa_req_if.sink        req_if,
   itoa_rsp_if.source      rsp_if
);

   localparam int OW = itoa_pkg::OPERAND_W;
   localparam logic [OW-1:0] WIDE_MASK = {OW{1'b1}} >> (OW - VALUE_WIDTH);
   localparam logic [OW-1:0] NARROW_MASK = {{(OW/2){1'b0}}, {(OW/2){1'b1}}};

   itoa_pkg::ctrl_word_type ctrl;

   logic [itoa_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic [OW-1:0]               val_ff, val_in;
   logic [itoa_pkg::BCD_W-1:0]  bcd_ff, bcd_in;
   logic [itoa_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [itoa_pkg::FUNC_W-1:0] func_ff, func_in;
   logic                        neg_ff, neg_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        accept, slot_free, emit, stall, jump;
   logic                        cnt_more, cnt_last, top_zero;
   logic [3:0]                  bcd_top, hex_top;
   logic [OW-1:0]               masked, mag;
   logic                        sign_bit, load_neg;
   logic [itoa_pkg::BCD_W-1:0]  bcd_d1, bcd_d2, bcd_d3, bcd_d4;

   assign ctrl = itoa_pkg::ucode_rom(pc_ff);

   assign req_if.ready    = (ctrl.op == itoa_pkg::OP_LOAD);
   assign accept          = req_if.valid && req_if.ready;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.character = rsp_char_ff;
   assign rsp_if.last     = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign emit      = (ctrl.op == itoa_pkg::OP_EMIT_CONST) ||
                      (ctrl.op == itoa_pkg::OP_EMIT_DEC) ||
                      (ctrl.op == itoa_pkg::OP_EMIT_HEX);
   assign stall     = emit && !slot_free;

   assign cnt_last = (cnt_ff == {{(itoa_pkg::CNT_W-1){1'b0}}, 1'b1});
   assign cnt_more = !cnt_last;
   assign bcd_top  = bcd_ff[itoa_pkg::BCD_W-1 -: 4];
   assign hex_top  = val_ff[OW-1 -: 4];
   assign top_zero = (bcd_top == 4'd0);

   // operand capture: mask to the operand width, take the magnitude if negative
   assign masked   = req_if.value & (req_if.wide ? WIDE_MASK : NARROW_MASK);
   assign sign_bit = req_if.wide ? masked[VALUE_WIDTH-1] : masked[OW/2-1];
   assign load_neg = (req_if.func == itoa_pkg::FMT_SIGNED) && sign_bit;
   assign mag      = load_neg ? ((~masked + {{(OW-1){1'b0}}, 1'b1}) &
                                 (req_if.wide ? WIDE_MASK : NARROW_MASK))
                              : masked;

   // four dabble steps fed by the top nibble of the shift register
   assign bcd_d1 = itoa_pkg::bcd_shift(bcd_ff, val_ff[OW-1]);
   assign bcd_d2 = itoa_pkg::bcd_shift(bcd_d1, val_ff[OW-2]);
   assign bcd_d3 = itoa_pkg::bcd_shift(bcd_d2, val_ff[OW-3]);
   assign bcd_d4 = itoa_pkg::bcd_shift(bcd_d3, val_ff[OW-4]);

   always_comb begin
      unique case (ctrl.cond)
         itoa_pkg::COND_NEXT:     jump = 1'b0;
         itoa_pkg::COND_ALWAYS:   jump = 1'b1;
         itoa_pkg::COND_IDLE:     jump = !accept;
         itoa_pkg::COND_FUNC_BAD: jump = (func_ff != itoa_pkg::FMT_SIGNED) &&
                                         (func_ff != itoa_pkg::FMT_UNSIGNED) &&
                                         (func_ff != itoa_pkg::FMT_HEX);
         itoa_pkg::COND_FUNC_HEX: jump = (func_ff == itoa_pkg::FMT_HEX);
         itoa_pkg::COND_POSITIVE: jump = !neg_ff;
         itoa_pkg::COND_CNT_MORE: jump = cnt_more;
         itoa_pkg::COND_SKIP:     jump = top_zero && cnt_more;
         default:                 jump = 1'b0;
      endcase
   end

   always_comb begin
      pc_in        = stall ? pc_ff : (jump ? ctrl.target : pc_ff + 1'b1);
      val_in       = val_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (!stall) begin
         unique case (ctrl.op)
            itoa_pkg::OP_NOP: begin
            end
            itoa_pkg::OP_LOAD: begin
               if (accept) begin
                  // narrow operands sit in the upper half so the top nibble leads
                  val_in  = req_if.wide ? mag : {mag[OW/2-1:0], {(OW/2){1'b0}}};
                  bcd_in  = '0;
                  cnt_in  = req_if.wide ? itoa_pkg::NIBBLES_WIDE
                                        : itoa_pkg::NIBBLES_NARROW;
                  func_in = req_if.func;
                  neg_in  = load_neg;
               end
            end
            itoa_pkg::OP_EMIT_CONST: begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ctrl.chr;
               rsp_last_in  = 1'b0;
            end
            itoa_pkg::OP_DABBLE: begin
               bcd_in = bcd_d4;
               val_in = {val_ff[OW-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end
            itoa_pkg::OP_SET_DIGITS: begin
               cnt_in = itoa_pkg::DIGITS_ALL;
            end
            itoa_pkg::OP_SKIP: begin
               // drop a leading zero, keep the final digit
               if (top_zero && cnt_more) begin
                  bcd_in = {bcd_ff[itoa_pkg::BCD_W-5:0], 4'd0};
                  cnt_in = cnt_ff - 1'b1;
               end
            end
            itoa_pkg::OP_EMIT_DEC: begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itoa_pkg::CHAR_ZERO + {3'd0, bcd_top};
               rsp_last_in  = cnt_last;
               bcd_in       = {bcd_ff[itoa_pkg::BCD_W-5:0], 4'd0};
               cnt_in       = cnt_ff - 1'b1;
            end
            itoa_pkg::OP_EMIT_HEX: begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = (hex_top < 4'd10)
                            ? itoa_pkg::CHAR_ZERO + {3'd0, hex_top}
                            : itoa_pkg::CHAR_LOW_A + {3'd0, hex_top - 4'd10};
               rsp_last_in  = cnt_last;
               val_in       = {val_ff[OW-5:0], 4'd0};
               cnt_in       = cnt_ff - 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= itoa_pkg::PC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      func_ff     <= func_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

### dv/itoa_checker.sv
// Scoreboard for the integer to ASCII formatter: watches both channels,
// predicts the character stream of every accepted number and compares.
// Depends on itoa_pkg and the channel interfaces in itoa_if.
module itoa_checker #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   itoa_req_if    req_mon,
   itoa_rsp_if    rsp_mon,
   output int     mismatch_count,
   output int     chars_outstanding
);

   typedef struct packed {
      logic [itoa_pkg::CHAR_W-1:0] character;
      logic                        last;
   } char_word_type;

   char_word_type expected_chars[$];

   // Append the decimal digits of mag, most significant first.
   task automatic add_decimal(inout char_word_type line[$], input logic [63:0] mag);
      logic [3:0]  digit_list[20];
      int          count;
      logic [63:0] rest;
      count = 0;
      rest  = mag;
      if (rest == 64'd0) begin
         line.push_back('{character: itoa_pkg::CHAR_ZERO, last: 1'b0});
      end
      while (rest != 64'd0) begin
         digit_list[count] = 4'(rest % 64'd10);
         rest              = rest / 64'd10;
         count++;
      end
      while (count > 0) begin
         count--;
         line.push_back('{character: itoa_pkg::CHAR_ZERO + {3'd0, digit_list[count]},
                          last: 1'b0});
      end
   endtask

   task automatic predict_number(input logic [itoa_pkg::FUNC_W-1:0] fmt, input logic wide,
                                 input logic [itoa_pkg::OPERAND_W-1:0] value);
      char_word_type line[$];
      logic [63:0]   mask;
      logic [63:0]   operand;
      logic [3:0]    nibble;
      int            width;
      int            ndig;
      mask    = wide ? ({64{1'b1}} >> (64 - VALUE_WIDTH)) : 64'h0000_0000_FFFF_FFFF;
      width   = wide ? VALUE_WIDTH : 32;
      operand = value & mask;
      case (fmt)
         itoa_pkg::FMT_SIGNED: begin
            if (operand[width-1]) begin
               line.push_back('{character: itoa_pkg::CHAR_MINUS, last: 1'b0});
               add_decimal(line, (~operand + 64'd1) & mask);
            end else begin
               add_decimal(line, operand);
            end
         end
         itoa_pkg::FMT_UNSIGNED: begin
            add_decimal(line, operand);
         end
         itoa_pkg::FMT_HEX: begin
            ndig = wide ? 16 : 8;
            line.push_back('{character: itoa_pkg::CHAR_ZERO, last: 1'b0});
            line.push_back('{character: itoa_pkg::CHAR_X, last: 1'b0});
            for (int i = ndig - 1; i >= 0; i--) begin
               nibble = operand[4*i +: 4];
               if (nibble < 4'd10) begin
                  line.push_back('{character: itoa_pkg::CHAR_ZERO + {3'd0, nibble},
                                   last: 1'b0});
               end else begin
                  line.push_back('{character: itoa_pkg::CHAR_LOW_A +
                                              {3'd0, nibble - 4'd10},
                                   last: 1'b0});
               end
            end
         end
         default: begin
            // unused selector: nothing comes out
         end
      endcase
      if (line.size() != 0) begin
         line[line.size()-1].last = 1'b1;
      end
      foreach (line[i]) begin
         expected_chars.push_back(line[i]);
      end
   endtask

   always @(posedge clock) begin
      char_word_type oldest;
      if (!reset) begin
         // check the output before queueing a newly accepted number
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected word: character %h last %b",
                      rsp_mon.character, rsp_mon.last);
               mismatch_count <= mismatch_count + 1;
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_mon.character !== oldest.character) begin
                  $error("character: expected %h, got %h", oldest.character,
                         rsp_mon.character);
                  mismatch_count <= mismatch_count + 1;
               end else if (rsp_mon.last !== oldest.last) begin
                  $error("last: expected %b, got %b", oldest.last, rsp_mon.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_number(req_mon.func, req_mon.wide, req_mon.value);
         end
      end
      chars_outstanding <= expected_chars.size();
   end

endmodule

### dv/testbench.sv
// Top of the formatter testbench: clock, reset, number stimulus and output
// back-pressure, with the verdict. Depends on itoa_pkg, itoa_if, the block
// and itoa_checker.
module testbench;

   localparam logic [itoa_pkg::FUNC_W-1:0] FMT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 220;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 64;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   chars_outstanding;
   int   item_index;
   int   words_taken;
   int   cycle_count;

   itoa_req_if req_if ();
   itoa_rsp_if rsp_if ();

   integer_to_ascii_formatter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   itoa_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_if),
      .rsp_mon           (rsp_if),
      .mismatch_count    (mismatch_count),
      .chars_outstanding (chars_outstanding)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [63:0] ten_to(input int k);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < k; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(0, 6))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, 32'($urandom_range(0, 20))};
         2: v = 64'($urandom_range(0, 20));
         3: v = ten_to($urandom_range(0, 19)) - 64'($urandom_range(0, 2)) + 64'd1;
         4: v = {32'hFFFF_FFFF, ~32'($urandom_range(0, 20))};
         5: v = {$urandom, ~32'($urandom_range(0, 20))};
         default: begin
            // sign-bit neighborhood of either width
            v = {$urandom, $urandom};
            v[63] = 1'($urandom_range(0, 1));
            v[62:40] = {23{v[63]}} ^ 23'($urandom_range(0, 1));
            v[31] = 1'($urandom_range(0, 1));
         end
      endcase
      return v;
   endfunction

   task automatic send_number(input logic [itoa_pkg::FUNC_W-1:0] fmt, input logic wide,
                              input logic [itoa_pkg::OPERAND_W-1:0] value);
      int gap;
      // every fourth stretch of 64 numbers goes back to back
      gap = ((item_index % 256) < 64) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= fmt;
      req_if.wide  <= wide;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      item_index++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (chars_outstanding != 0) @(posedge clock);
   endtask

   // output side: random stalls, back-to-back stretches and one long hold-off
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      words_taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (words_taken == 60) begin
            stall = LONG_HOLD;
         end else if ((words_taken % 600) < 150) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 12);
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         words_taken++;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** integer_to_ascii_formatter: FAILED **");
      $finish;
   end

   initial begin
      logic [itoa_pkg::FUNC_W-1:0] fmt;
      logic                        wide;
      int                          counted;
      int                          r;
      item_index = 0;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.func  <= itoa_pkg::FMT_SIGNED;
      req_if.wide  <= 1'b0;
      req_if.value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, extremes, most negative values, ignored upper bits
      send_number(itoa_pkg::FMT_SIGNED,   1'b0, 64'd0);
      send_number(itoa_pkg::FMT_SIGNED,   1'b0, 64'd1);
      send_number(itoa_pkg::FMT_SIGNED,   1'b0, 64'h0000_0000_FFFF_FFFF);
      send_number(itoa_pkg::FMT_SIGNED,   1'b0, 64'h0000_0000_8000_0000);
      send_number(itoa_pkg::FMT_SIGNED,   1'b0, 64'hFFFF_FFFF_7FFF_FFFF);
      send_number(itoa_pkg::FMT_SIGNED,   1'b0, 64'hDEAD_BEEF_0000_0005);
      send_number(itoa_pkg::FMT_SIGNED,   1'b1, 64'd0);
      send_number(itoa_pkg::FMT_SIGNED,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(itoa_pkg::FMT_SIGNED,   1'b1, 64'h8000_0000_0000_0000);
      send_number(itoa_pkg::FMT_SIGNED,   1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
      send_number(itoa_pkg::FMT_UNSIGNED, 1'b0, 64'd0);
      send_number(itoa_pkg::FMT_UNSIGNED, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(itoa_pkg::FMT_UNSIGNED, 1'b0, 64'hA5A5_A5A5_3B9A_CA00);
      send_number(itoa_pkg::FMT_UNSIGNED, 1'b1, 64'd0);
      send_number(itoa_pkg::FMT_UNSIGNED, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(itoa_pkg::FMT_UNSIGNED, 1'b1, 64'h8AC7_2304_89E8_0000);
      send_number(itoa_pkg::FMT_HEX,      1'b0, 64'd0);
      send_number(itoa_pkg::FMT_HEX,      1'b0, 64'h1234_5678_FFFF_FFFF);
      send_number(itoa_pkg::FMT_HEX,      1'b0, 64'hFFFF_FFFF_9ABC_DEF0);
      send_number(itoa_pkg::FMT_HEX,      1'b1, 64'd0);
      send_number(itoa_pkg::FMT_HEX,      1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(itoa_pkg::FMT_HEX,      1'b1, 64'h0123_4567_89AB_CDEF);
      send_number(FMT_UNUSED,             1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(FMT_UNUSED,             1'b1, 64'd12345);
      send_number(itoa_pkg::FMT_SIGNED,   1'b1, 64'hFFFF_FFFF_FFFF_FFF6);
      drain_results();

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         r = $urandom_range(0, 15);
         fmt  = (r < 5) ? itoa_pkg::FMT_SIGNED : (r < 10) ? itoa_pkg::FMT_UNSIGNED :
                (r < 15) ? itoa_pkg::FMT_HEX : FMT_UNUSED;
         wide = 1'($urandom_range(0, 1));
         send_number(fmt, wide, pick_value());
         if (fmt != FMT_UNUSED) begin
            counted++;
            // hold the input once mid-run until the output has caught up
            if (counted == RANDOM_ITEMS / 2) begin
               drain_results();
            end
         end
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && chars_outstanding == 0) begin
         $display("** integer_to_ascii_formatter: PASSED **");
      end else begin
         if (chars_outstanding != 0) begin
            $error("%0d expected characters never arrived", chars_outstanding);
         end
         $display("** integer_to_ascii_formatter: FAILED **");
      end
      $finish;
   end

endmodule
